// ===== sv/sha512_pkg.sv =====
// SHA-512 engine package: types, round constants and round functions.
// Used by every module of the engine; depends on nothing.
package sha512_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned LenOffset  = 112;
  localparam int unsigned Rounds     = 80;
  localparam logic [7:0]  PadByte    = 8'h80;

  // One beat handed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_e;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
    rotr64 = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ===== sv/sha512_queue.sv =====
// Two-entry queue that parts the front end from the compression back end.
// Depends on sha512_pkg for the item type.
module sha512_queue
  import sha512_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // Storage for the queued beats.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/sha512_front.sv =====
// Front end: accepts input beats, drops empty ones and forwards the rest.
// Depends on sha512_pkg for the item type.
module sha512_front
  import sha512_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       message_end_i,
  output logic       fw_valid_o,
  input  logic       fw_ready_i,
  output item_t      fw_item_o
);

  logic  hold_q;
  item_t item_q;
  logic  useful;

  // A beat with neither byte nor end changes nothing and is dropped here.
  assign useful     = byte_present_i || message_end_i;
  assign in_ready_o = !hold_q || fw_ready_i;
  assign fw_valid_o = hold_q;
  assign fw_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_q <= in_valid_i && useful;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{data: data_byte_i, present: byte_present_i, last: message_end_i};
    end
  end

endmodule

// ===== sv/sha512_back.sv =====
// Back end: block buffer, 80-round iterative compression, padding and digest output.
// Depends on sha512_pkg for constants, round functions and the state type.
module sha512_back
  import sha512_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        it_valid_i,
  output logic        it_ready_o,
  input  item_t       it_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  back_state_e state_q, state_d;

  // The block is held as sixteen big-endian 64-bit words.
  logic [63:0]  buf_q [16];
  logic [6:0]   fill_q;
  logic [127:0] bits_q;
  logic [63:0]  chain_q [8];
  logic [63:0]  v_q [8];
  logic [63:0]  w_q [16];
  logic [6:0]   rnd_q;
  logic         fin_q;      // finishing sequence in progress
  logic         extra_q;    // length block still to come after this one
  logic         pad_done_q; // padding has been applied for this finish
  logic [2:0]   widx_q;

  logic         take;
  logic [6:0]   fill_inc;
  logic [63:0]  w_new, t1, t2;
  logic [3:0]   ridx;

  assign it_ready_o = (state_q == ST_IDLE);
  assign take = it_valid_i && it_ready_o;
  assign fill_inc = fill_q + 7'd1;
  assign ridx = rnd_q[3:0];

  // One round of the compression.
  always_comb begin
    if (rnd_q < 7'd16) begin
      w_new = buf_q[ridx];
    end else begin
      w_new = small_sigma1(w_q[4'(ridx - 4'd2)]) + w_q[4'(ridx - 4'd7)]
            + small_sigma0(w_q[4'(ridx - 4'd15)]) + w_q[ridx];
    end
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[rnd_q] + w_new;
    t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (it_item_i.present && fill_inc == 7'd0) state_d = ST_ROUND;
          else if (it_item_i.last) state_d = ST_PAD;
        end
      end
      ST_ROUND: if (rnd_q == 7'(Rounds - 1)) state_d = ST_ADD;
      ST_ADD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (!pad_done_q || extra_q) state_d = ST_PAD;
        else state_d = ST_EMIT;
      end
      ST_PAD:  state_d = ST_ROUND;
      ST_EMIT: if (out_ready_i && widx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Control registers and chaining words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      bits_q     <= '0;
      rnd_q      <= '0;
      fin_q      <= 1'b0;
      extra_q    <= 1'b0;
      pad_done_q <= 1'b0;
      widx_q     <= '0;
      for (int k = 0; k < 8; k++) chain_q[k] <= InitHash[k];
    end else begin
      case (state_q)
        ST_IDLE: begin
          rnd_q <= '0;
          if (take) begin
            fin_q      <= it_item_i.last;
            pad_done_q <= 1'b0;
            if (it_item_i.present) begin
              fill_q <= fill_inc;
              bits_q <= bits_q + 128'd8;
            end
          end
        end
        ST_ROUND: rnd_q <= rnd_q + 7'd1;
        ST_ADD: begin
          for (int k = 0; k < 8; k++) chain_q[k] <= chain_q[k] + v_q[k];
          if (fin_q && pad_done_q && !extra_q) widx_q <= '0;
        end
        ST_PAD: begin
          rnd_q      <= '0;
          pad_done_q <= 1'b1;
          // A second pass is needed when the pad leaves no room for the length.
          extra_q <= (fill_q >= 7'(LenOffset));
          fill_q  <= '0;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              fin_q  <= 1'b0;
              bits_q <= '0;
              fill_q <= '0;
              for (int k = 0; k < 8; k++) chain_q[k] <= InitHash[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Block buffer, working variables and message schedule.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take && it_item_i.present) begin
          buf_q[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] <= it_item_i.data;
        end
      end
      ST_PAD: begin
        // Pad byte and zero fill; the whole block is cleared for the length-only pass.
        for (int j = 0; j < 16; j++) begin
          for (int b = 0; b < 8; b++) begin
            if (extra_q) begin
              buf_q[4'(j)][8 * (7 - b) +: 8] <= '0;
            end else if (8 * j + b == int'(fill_q)) begin
              buf_q[4'(j)][8 * (7 - b) +: 8] <= PadByte;
            end else if (8 * j + b > int'(fill_q)) begin
              buf_q[4'(j)][8 * (7 - b) +: 8] <= '0;
            end
          end
        end
        // The length goes in unless a further block follows.
        if (extra_q || fill_q < 7'(LenOffset)) begin
          buf_q[14] <= bits_q[127:64];
          buf_q[15] <= bits_q[63:0];
        end
        for (int k = 0; k < 8; k++) v_q[k] <= chain_q[k];
      end
      ST_ROUND: begin
        w_q[ridx] <= w_new;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      default: begin
        if (state_q == ST_IDLE || state_q == ST_ADD) begin
          for (int k = 0; k < 8; k++) v_q[k] <= v_q[k];
        end
      end
    endcase
    if (state_q == ST_IDLE && take && it_item_i.present && fill_inc == 7'd0) begin
      for (int k = 0; k < 8; k++) v_q[k] <= chain_q[k];
    end
  end

  assign out_valid_o   = (state_q == ST_EMIT);
  assign digest_word_o = chain_q[widx_q];
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 3'd7);

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q < 7'(Rounds)) else $error("round counter overrun");
  a_emit_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> fin_q) else $error("digest without finish");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !it_ready_o) else $error("input taken during output");

endmodule

// ===== sv/sha512_hash_engine_top.sv =====
// SHA-512 hash engine top level: front end, queue and compression back end.
// Depends on sha512_pkg, sha512_front, sha512_queue and sha512_back.
//
// Usage: message bytes arrive one beat at a time on the input channel
// (data_byte_i, byte_present_i, message_end_i, handshake in_valid_i/in_ready_o).
// A beat with message_end_i set finishes the message; the engine then sends
// eight 64-bit digest words, most significant first, on the output channel
// (out_valid_o/out_ready_i), with word_index_o and last_word_o.
// The back end writes each byte beat into the block buffer; the beat that
// completes a 128-byte block starts the iterative 80-round compression,
// one round per cycle through a single round unit.
// Finishing pads the block and compresses it, plus a length-only block
// when the padding spills into a second block; a finishing beat that also
// completes a block first has that block compressed. Digest words follow.
// A two-beat queue lets the front end keep accepting while the back end works.
// Reset loads the initial hash values and clears the counts and queue.
// When the receiver stalls the current digest word is held and no further
// input is consumed by the back end until all eight words have gone.
module sha512_hash_engine_top
  import sha512_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic  fw_valid, fw_ready, q_valid, q_ready;
  item_t fw_item, q_item;

  sha512_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .byte_present_i,
    .message_end_i, .fw_valid_o(fw_valid), .fw_ready_i(fw_ready), .fw_item_o(fw_item)
  );

  sha512_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fw_valid), .wr_ready_o(fw_ready), .wr_item_i(fw_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_item_o(q_item)
  );

  sha512_back u_back (
    .clk_i, .rst_ni, .it_valid_i(q_valid), .it_ready_o(q_ready), .it_item_i(q_item),
    .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o, .last_word_o
  );

endmodule

// ===== tb/sv/sha512_hash_engine_checker.sv =====
// Checker for the SHA-512 hash engine: watches both channels, predicts digests.
// Depends on sha512_pkg for the round, initial hash and padding constants.
module sha512_hash_engine_checker
  import sha512_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_seen_o
);

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [63:0]  chain_q [8];
  logic [7:0]   block_q [128];
  logic [6:0]   fill_q;
  logic [127:0] length_bits_q;
  digest_beat_t digest_queue [$];

  assign pending_o = digest_queue.size();

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // One full compression of the held block into the chaining words.
  task automatic compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = '0;
      for (int k = 0; k < 8; k++) w[t] = {w[t][55:0], block_q[t * 8 + k]};
    end
    for (int t = 16; t < 80; t++) begin
      s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
      s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int k = 0; k < 8; k++) v[k] = chain_q[k];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain_q[k] += v[k];
  endtask

  // Apply one accepted input beat to the predicted state.
  task automatic absorb_beat(input logic [7:0] b, input logic present, input logic fin);
    int i;
    digest_beat_t d;
    if (present) begin
      block_q[fill_q] = b;
      length_bits_q += 128'd8;
      if (fill_q == 7'd127) begin
        compress();
        fill_q = '0;
      end else begin
        fill_q++;
      end
    end
    if (fin) begin
      i = fill_q;
      block_q[i] = PadByte;
      i++;
      if (i > LenOffset) begin
        while (i < BlockBytes) begin
          block_q[i] = 8'h00;
          i++;
        end
        compress();
        i = 0;
      end
      while (i < LenOffset) begin
        block_q[i] = 8'h00;
        i++;
      end
      for (int k = 0; k < 16; k++) block_q[LenOffset + k] = length_bits_q[127 - 8 * k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        d.word = chain_q[k];
        d.index = 3'(k);
        d.last = (k == 7);
        digest_queue.push_back(d);
      end
      for (int k = 0; k < 8; k++) chain_q[k] = InitHash[k];
      fill_q = '0;
      length_bits_q = '0;
    end
  endtask

  // Sample both channels at the edge and compare digest beats in order.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t e;
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) chain_q[k] = InitHash[k];
      fill_q = '0;
      length_bits_q = '0;
      digest_queue.delete();
      fail_count_o <= 0;
      digests_seen_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) absorb_beat(data_byte_i, byte_present_i, message_end_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest beat %h idx %0d", $time, digest_word_i,
                   word_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = digest_queue.pop_front();
          if (e.word !== digest_word_i || e.index !== word_index_i ||
              e.last !== last_word_i) begin
            $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     e.word, e.index, e.last, digest_word_i, word_index_i, last_word_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (last_word_i) digests_seen_o <= digests_seen_o + 1;
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_sha512_hash_engine_top.sv =====
// Testbench top for the SHA-512 hash engine: drives messages, sets idling phases.
// Depends on sha512_hash_engine_top and sha512_hash_engine_checker.
module tb_sha512_hash_engine_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  int          fail_count, pending, digests_seen;
  int          send_idle_pct, recv_stall_pct;
  int          cycle_count = 0;
  int          beats_sent = 0;
  localparam int CycleLimit = 400000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha512_hash_engine_top dut (.*);

  sha512_hash_engine_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i,
    .byte_present_i, .message_end_i, .out_valid_i(out_valid_o), .out_ready_i,
    .digest_word_i(digest_word_o), .word_index_i(word_index_o),
    .last_word_i(last_word_o), .fail_count_o(fail_count), .pending_o(pending),
    .digests_seen_o(digests_seen)
  );

  // Receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sha512_hash_engine_top test failed");
      $finish;
    end
  end

  // Send one beat, with optional idle cycles ahead of it, and wait for acceptance.
  // Valid stays high after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_beat(input logic [7:0] b, input logic present, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    byte_present_i <= present;
    message_end_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // A whole message of random bytes, with occasional empty beats in it.
  task automatic send_message(input int len, input logic end_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(31) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, 1'b0);
    end
    send_beat(8'($urandom), end_byte, 1'b1);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  initial begin
    set_phase(0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, idle beat, extreme bytes, a final pad at the
    // last byte of the block, and an end beat that also completes a block.
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_message(127, 1'b0);
    send_message(127, 1'b1);

    // Random short messages across all idling phases.
    for (int p = 0; p < 4; p++) begin
      set_phase(p);
      for (int m = 0; m < 6; m++) send_message($urandom_range(7), 1'($urandom_range(1)));
    end
    in_valid_i <= 1'b0;
    set_phase(0);

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats across four idling phases; %0d digests checked.",
             beats_sent, digests_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("sha512_hash_engine_top test passed");
    end else begin
      $display("sha512_hash_engine_top test failed");
    end
    $finish;
  end

endmodule

// ===== sha512_hash_engine_top.f =====
sv/sha512_pkg.sv
sv/sha512_queue.sv
sv/sha512_front.sv
sv/sha512_back.sv
sv/sha512_hash_engine_top.sv
tb/sv/sha512_hash_engine_checker.sv
tb/sv/tb_sha512_hash_engine_top.sv
